@@ rtl/obm_pkg.sv @@
// Shared types and constants for the order book matcher.
`timescale 1ns / 1ps
package obm_pkg;
  localparam int BOOK_DEPTH = 16;
  localparam int IDX_W = $clog2(BOOK_DEPTH);
  localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;

  typedef struct packed {
    logic        side;
    logic [31:0] ref_no;
    logic [31:0] price;
    logic [23:0] qty;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN, S_TRADE, S_DROPJ, S_DROP0, S_STAT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic ld_in;
    logic set_j;
    logic dec_j;
    logic trade;
    logic drop_j;
    logic drop_0;
    logic ld_stat;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_ge2;
    logic match;
    logic j_is1;
    logic out_free;
  } stat_t;
endpackage

@@ rtl/obm_ctrl.sv @@
// Sequencer for insert, scan, trade, removal and status steps.
`timescale 1ns / 1ps
module obm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  obm_pkg::stat_t st,
  output logic          idle,
  output obm_pkg::cmd_t cmd
);
  obm_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      obm_pkg::S_IDLE:  if (in_fire) state_nxt = obm_pkg::S_CHECK;
      obm_pkg::S_CHECK: state_nxt = st.cnt_ge2 ? obm_pkg::S_SCAN : obm_pkg::S_STAT;
      obm_pkg::S_SCAN: begin
        if (st.match) state_nxt = obm_pkg::S_TRADE;
        else if (st.j_is1) state_nxt = obm_pkg::S_STAT;
      end
      obm_pkg::S_TRADE: if (st.out_free) state_nxt = obm_pkg::S_DROPJ;
      obm_pkg::S_DROPJ: state_nxt = obm_pkg::S_DROP0;
      obm_pkg::S_DROP0: state_nxt = obm_pkg::S_CHECK;
      obm_pkg::S_STAT:  if (st.out_free) state_nxt = obm_pkg::S_IDLE;
      default:          state_nxt = obm_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state_r)
      obm_pkg::S_IDLE: begin
        idle       = 1'b1;
        cmd.ld_in  = in_fire;
      end
      obm_pkg::S_CHECK: cmd.set_j = 1'b1;
      obm_pkg::S_SCAN:  cmd.dec_j = !st.match && !st.j_is1;
      obm_pkg::S_TRADE: cmd.trade = st.out_free;
      obm_pkg::S_DROPJ: cmd.drop_j = 1'b1;
      obm_pkg::S_DROP0: cmd.drop_0 = 1'b1;
      obm_pkg::S_STAT:  cmd.ld_stat = st.out_free;
      default: ;
    endcase
  end
endmodule

@@ rtl/obm_datapath.sv @@
// Book registers, scan index, trade arithmetic and the output register.
`timescale 1ns / 1ps
module obm_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  obm_pkg::cmd_t  cmd,
  output obm_pkg::stat_t st,
  input  obm_pkg::entry_t in_entry,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_kind,
  output logic [31:0]    out_buy,
  output logic [31:0]    out_sell,
  output logic [31:0]    out_price,
  output logic [23:0]    out_qty,
  output logic           out_drop,
  output logic [4:0]     out_cnt
);
  obm_pkg::entry_t book_r [obm_pkg::BOOK_DEPTH];
  logic [obm_pkg::CNT_W-1:0] cnt_r;
  logic [obm_pkg::IDX_W-1:0] j_r;
  logic                      drop_r;
  logic                      valid_r;
  logic                      kind_r;
  logic [31:0]               buy_r, sell_r, price_r;
  logic [23:0]               qty_r;
  logic                      odrop_r;
  logic [4:0]                ocnt_r;

  obm_pkg::entry_t head, cand;
  logic [23:0]     tq;
  logic            full;
  logic            qj_zero, q0_zero;

  assign head    = book_r[0];
  assign cand    = book_r[j_r];
  assign tq      = (head.qty < cand.qty) ? head.qty : cand.qty;
  assign full    = (cnt_r == obm_pkg::CNT_W'(obm_pkg::BOOK_DEPTH));
  assign qj_zero = (cand.qty == 24'd0);
  assign q0_zero = (head.qty == 24'd0);

  assign st.cnt_ge2  = (cnt_r >= obm_pkg::CNT_W'(2));
  assign st.match    = (cand.side != head.side) && (cand.price == head.price);
  assign st.j_is1    = (j_r == obm_pkg::IDX_W'(1));
  assign st.out_free = !valid_r || out_ready;

  // book entries: append, quantity update, compaction
  always_ff @(posedge clk) begin
    for (int i = 0; i < obm_pkg::BOOK_DEPTH; i++) begin
      if (cmd.ld_in && !full && cnt_r[obm_pkg::IDX_W-1:0] == obm_pkg::IDX_W'(i)) begin
        book_r[i] <= in_entry;
      end else if (cmd.trade && (i == 0 || j_r == obm_pkg::IDX_W'(i))) begin
        book_r[i].qty <= book_r[i].qty - tq;
      end else if (i < obm_pkg::BOOK_DEPTH - 1) begin
        if ((cmd.drop_j && qj_zero && obm_pkg::IDX_W'(i) >= j_r) ||
            (cmd.drop_0 && q0_zero)) begin
          book_r[i] <= book_r[(i + 1) % obm_pkg::BOOK_DEPTH];
        end
      end
    end
  end

  // count, scan index and drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      j_r    <= '0;
      drop_r <= 1'b0;
    end else begin
      if (cmd.ld_in) begin
        drop_r <= full;
        if (!full) cnt_r <= cnt_r + obm_pkg::CNT_W'(1);
      end else if ((cmd.drop_j && qj_zero) || (cmd.drop_0 && q0_zero)) begin
        cnt_r <= cnt_r - obm_pkg::CNT_W'(1);
      end
      if (cmd.set_j) j_r <= obm_pkg::IDX_W'(cnt_r - obm_pkg::CNT_W'(1));
      else if (cmd.dec_j) j_r <= j_r - obm_pkg::IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.trade || cmd.ld_stat) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trade) begin
      kind_r  <= obm_pkg::KIND_TRADE;
      buy_r   <= (head.side == obm_pkg::SIDE_BUY) ? head.ref_no : cand.ref_no;
      sell_r  <= (head.side == obm_pkg::SIDE_BUY) ? cand.ref_no : head.ref_no;
      price_r <= head.price;
      qty_r   <= tq;
      odrop_r <= 1'b0;
      ocnt_r  <= '0;
    end else if (cmd.ld_stat) begin
      kind_r  <= obm_pkg::KIND_STATUS;
      buy_r   <= '0;
      sell_r  <= '0;
      price_r <= '0;
      qty_r   <= '0;
      odrop_r <= drop_r;
      ocnt_r  <= 5'(cnt_r);
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_buy   = buy_r;
  assign out_sell  = sell_r;
  assign out_price = price_r;
  assign out_qty   = qty_r;
  assign out_drop  = odrop_r;
  assign out_cnt   = ocnt_r;
endmodule

@@ rtl/order_book_matcher.sv @@
// Top level of the order book matcher.
`timescale 1ns / 1ps
// Each accepted order is appended to a 16-entry arrival-ordered book (dropped and
// flagged when full), then matched: the oldest entry is compared against entries
// from newest to second-oldest, one entry per clock, and each equal-price
// opposite-side hit emits a trade for the smaller quantity, after which filled
// entries are removed. One status transfer (tuser=1, tlast=1) ends every order.
// Steps: the order is taken in the idle state; each match attempt runs a setup
// step and a scan of up to (entries-1) entries on the single shared comparator;
// a trade runs a trade and two removal steps; the status item is loaded last.
// Trade and status steps wait while the output register holds an untaken item.
// A new order is taken only after the status item has been loaded into the
// output register.
module order_book_matcher (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // side[0], ref[32:1], price[64:33], qty[88:65], zero pad
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // buy_ref[31:0], sell_ref[63:32], trade_price[95:64], trade_qty[119:96],
  // dropped_full[120], book_entries[125:121], zero pad
  output logic [127:0] out_tdata,
  // item_kind
  output logic         out_tuser,
  output logic         out_tlast
);
  obm_pkg::cmd_t   cmd;
  obm_pkg::stat_t  st;
  obm_pkg::entry_t in_entry;
  logic            idle;
  logic [31:0]     buy, sell, price;
  logic [23:0]     qty;
  logic            drop;
  logic [4:0]      cnt;

  assign in_tready = idle;
  assign in_entry.side   = in_tdata[0];
  assign in_entry.ref_no = in_tdata[32:1];
  assign in_entry.price  = in_tdata[64:33];
  assign in_entry.qty    = in_tdata[88:65];

  obm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && idle),
    .st      (st),
    .idle    (idle),
    .cmd     (cmd)
  );

  obm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_entry  (in_entry),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_buy   (buy),
    .out_sell  (sell),
    .out_price (price),
    .out_qty   (qty),
    .out_drop  (drop),
    .out_cnt   (cnt)
  );

  // pack results; status items carry tlast
  assign out_tdata = {2'b00, cnt, drop, qty, price, sell, buy};
  assign out_tlast = out_tuser;
endmodule

@@ tb/tb_order_book_matcher.sv @@
// Self-checking testbench for the order book matcher.
`timescale 1ns / 1ps
module tb_order_book_matcher;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        kind;
    logic [31:0] buy_ref;
    logic [31:0] sell_ref;
    logic [31:0] price;
    logic [23:0] qty;
    logic        dropped;
    logic [4:0]  entries;
    logic        last;
  } fill_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  // book copy kept in arrival order, index 0 oldest
  obm_pkg::entry_t book [obm_pkg::BOOK_DEPTH];
  int unsigned     book_cnt;
  fill_t           fills_due [$];

  int unsigned errors;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_cycles;
  int unsigned quiet_cycles;
  logic        done_sending;

  order_book_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // remove one slot, shifting younger entries down
  task automatic book_remove(input int unsigned k);
    for (int unsigned i = k; i + 1 < book_cnt; i++) book[i] = book[i + 1];
    book_cnt--;
  endtask

  // append the order, run matching and queue the expected transfers
  task automatic match_order(input obm_pkg::entry_t o);
    fill_t       f;
    logic        drop;
    int unsigned j;
    logic [23:0] tq;
    drop = 1'b0;
    if (book_cnt >= obm_pkg::BOOK_DEPTH) begin
      drop = 1'b1;
    end else begin
      book[book_cnt] = o;
      book_cnt++;
    end
    while (book_cnt >= 2) begin
      j = 0;
      for (int unsigned k = book_cnt - 1; k >= 1; k--) begin
        if (book[k].side != book[0].side && book[k].price == book[0].price) begin
          j = k;
          break;
        end
      end
      if (j == 0) break;
      tq = (book[0].qty < book[j].qty) ? book[0].qty : book[j].qty;
      f = '0;
      f.kind = obm_pkg::KIND_TRADE;
      f.buy_ref = (book[0].side == obm_pkg::SIDE_BUY) ? book[0].ref_no : book[j].ref_no;
      f.sell_ref = (book[0].side == obm_pkg::SIDE_BUY) ? book[j].ref_no : book[0].ref_no;
      f.price = book[0].price;
      f.qty = tq;
      fills_due.push_back(f);
      book[0].qty -= tq;
      book[j].qty -= tq;
      if (book[j].qty == 0) book_remove(j);
      if (book[0].qty == 0) book_remove(0);
    end
    f = '0;
    f.kind = obm_pkg::KIND_STATUS;
    f.dropped = drop;
    f.entries = book_cnt[4:0];
    f.last = 1'b1;
    fills_due.push_back(f);
  endtask

  // offer one order until accepted; tvalid stays up when the next one follows
  task automatic send_order(input logic side, input logic [31:0] rf,
                            input logic [31:0] px, input logic [23:0] q);
    obm_pkg::entry_t o;
    while (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    o.side = side;
    o.ref_no = rf;
    o.price = px;
    o.qty = q;
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, q, px, rf, side};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    match_order(o);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (fills_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    fill_t got;
    fill_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.kind = out_tuser;
      got.buy_ref = out_tdata[31:0];
      got.sell_ref = out_tdata[63:32];
      got.price = out_tdata[95:64];
      got.qty = out_tdata[119:96];
      got.dropped = out_tdata[120];
      got.entries = out_tdata[125:121];
      got.last = out_tlast;
      if (fills_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
      end else begin
        want = fills_due.pop_front();
        if (got.kind !== want.kind || got.buy_ref !== want.buy_ref ||
            got.sell_ref !== want.sell_ref || got.price !== want.price ||
            got.qty !== want.qty || got.dropped !== want.dropped ||
            got.entries !== want.entries || got.last !== want.last) begin
          errors++;
          $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_cycles != 0)
      quiet_cycles <= 0;
    else if (rst_n && !done_sending)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // extremes, zero quantity, partial fills, stalled oldest
  task automatic test_directed();
    send_order(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_order(1'b1, 32'h0, 32'hFFFF_FFFF, 24'h00_0001);
    send_order(1'b1, 32'h1234_5678, 32'hFFFF_FFFF, 24'hFF_FFFF);
    // clear the leftover sell so the book starts empty again
    send_order(1'b0, 32'h31, 32'hFFFF_FFFF, 24'h00_0001);
    send_order(1'b0, 32'h0, 32'h0, 24'h0);
    send_order(1'b1, 32'hAAAA_5555, 32'h0, 24'h00_0010);
    send_order(1'b0, 32'h5555_AAAA, 32'h0, 24'h00_0008);
    send_order(1'b0, 32'h11, 32'h0, 24'h00_0008);
    // oldest stalled while younger ones could match
    send_order(1'b0, 32'h21, 32'd500, 24'd5);
    send_order(1'b0, 32'h22, 32'd600, 24'd5);
    send_order(1'b1, 32'h23, 32'd600, 24'd3);
    send_order(1'b1, 32'h24, 32'd500, 24'd9);
    // empty the book again
    send_order(1'b1, 32'h25, 32'd600, 24'd2);
    send_order(1'b0, 32'h26, 32'd500, 24'd4);
    wait_drained();
  endtask

  // fill the book past full while the receiver holds off
  task automatic test_full_book();
    hold_cycles <= 400;
    for (int i = 0; i < 19; i++)
      send_order(1'b0, $urandom, 32'd7000 + i, 24'($urandom_range(50, 1)));
    wait_drained();
    for (int i = 0; i < 19; i++)
      send_order(1'b1, $urandom, 32'd7000 + i, 24'($urandom_range(60, 0)));
    wait_drained();
  endtask

  // random orders on a few price levels so matches are frequent
  task automatic test_random(input int unsigned n);
    logic [31:0] px;
    for (int unsigned i = 0; i < n; i++) begin
      px = 32'd100 + $urandom_range(2, 0);
      send_order(1'($urandom_range(1, 0)), $urandom, px,
                 ($urandom_range(19, 0) == 0) ? 24'($urandom) : 24'($urandom_range(40, 0)));
    end
    wait_drained();
  endtask

  initial begin
    errors = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    done_sending = 1'b0;
    book_cnt = 0;
    src_idle_pct = 10;
    snk_idle_pct = 83;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(45);
    src_idle_pct = 83;
    snk_idle_pct = 10;
    test_random(45);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(45);
    // a full book never drains, so this runs last
    test_full_book();
    done_sending = 1'b1;
    if (errors == 0 && fills_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (fills_due.size() != 0)
        $display("%0t: %0d expected transfers never arrived", $time, fills_due.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/obm_pkg.sv
rtl/obm_ctrl.sv
rtl/obm_datapath.sv
rtl/order_book_matcher.sv
tb/tb_order_book_matcher.sv
